// File: hdl/ipprsp_pkg.sv
// Shared types and codes for the IPP response attribute parser.
package ipprsp_pkg;

   // Bytes at or below this value after the header are group delimiters
   localparam logic [7:0] DELIM_MAX     = 8'h0F;
   localparam logic [7:0] TAG_OPERATION = 8'h01;
   localparam logic [7:0] TAG_JOB       = 8'h02;
   localparam logic [7:0] TAG_END       = 8'h03;

   localparam logic [2:0] HDR_LAST_IDX  = 3'd7;

   localparam logic [3:0] ROLE_VER_MAJOR = 4'd0;
   localparam logic [3:0] ROLE_VER_MINOR = 4'd1;
   localparam logic [3:0] ROLE_STATUS    = 4'd2;
   localparam logic [3:0] ROLE_REQID     = 4'd3;
   localparam logic [3:0] ROLE_DELIM     = 4'd4;
   localparam logic [3:0] ROLE_TAG       = 4'd5;
   localparam logic [3:0] ROLE_NAMELEN   = 4'd6;
   localparam logic [3:0] ROLE_NAME      = 4'd7;
   localparam logic [3:0] ROLE_VALLEN    = 4'd8;
   localparam logic [3:0] ROLE_VALUE     = 4'd9;
   localparam logic [3:0] ROLE_IGNORED   = 4'd10;

   localparam logic [1:0] GROUP_OPERATION = 2'd0;
   localparam logic [1:0] GROUP_JOB       = 2'd1;
   localparam logic [1:0] GROUP_PRINTER   = 2'd2;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_HDR_SHORT = 2'd1;
   localparam logic [1:0] ERR_TRUNC     = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [3:0]  byte_role;
      logic [1:0]  group_code;
      logic [7:0]  value_tag;
      logic        repeat_name;
      logic        attr_done;
      logic [15:0] status_word;
      logic [31:0] request_word;
      logic [1:0]  end_error;
      logic        final_out;
   } rsp_item_type;

endpackage

// File: hdl/ipp_response_tlv_parser.sv
// IPP response parser top level: labels each response byte with its role.
// Path: accepted items pass through the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; parse state updates as an
// item moves into the result register, so each byte sees its predecessor's state.
// Reset: synchronous, active high; clears both stage valids and all parse state.
// After an item marked final, the parse state returns to its reset values.
module ipp_response_tlv_parser
   import ipprsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_TAG,
      PH_NLEN_HI,
      PH_NLEN_LO,
      PH_NAME,
      PH_VLEN_HI,
      PH_VLEN_LO,
      PH_VALUE,
      PH_DONE
   } phase_type;

   // Input register
   logic         in_valid_ff;
   req_item_type in_item_ff;

   // Result register
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   // Parse state
   phase_type   phase_ff, phase_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;
   logic [15:0] status_ff, status_in;
   logic [31:0] request_ff, request_in;
   logic [1:0]  group_ff, group_in;
   logic [7:0]  tag_ff, tag_in;
   logic [15:0] remain_ff, remain_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic        empty_name_ff, empty_name_in;

   logic         out_free;
   logic         advance;
   logic [3:0]   role;
   logic         done;
   logic [1:0]   err;
   logic [15:0]  len_word;
   logic [7:0]   b;
   logic         fin;
   rsp_item_type result;

   // The result register frees up when empty or when its item is taken
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign b        = in_item_ff.in_byte;
   assign fin      = in_item_ff.is_final;
   assign len_word = {len_hi_ff, b};

   // Next parse state and labels for the byte in the input register
   always_comb begin
      phase_in      = phase_ff;
      hdr_idx_in    = hdr_idx_ff;
      status_in     = status_ff;
      request_in    = request_ff;
      group_in      = group_ff;
      tag_in        = tag_ff;
      remain_in     = remain_ff;
      len_hi_in     = len_hi_ff;
      empty_name_in = empty_name_ff;
      role          = ROLE_IGNORED;
      done          = 1'b0;
      err           = ERR_NONE;

      case (phase_ff)
         PH_HEADER: begin
            if (hdr_idx_ff == 3'd0) begin
               role = ROLE_VER_MAJOR;
            end else if (hdr_idx_ff == 3'd1) begin
               role = ROLE_VER_MINOR;
            end else if (hdr_idx_ff < 3'd4) begin
               role      = ROLE_STATUS;
               status_in = {status_ff[7:0], b};
            end else begin
               role       = ROLE_REQID;
               request_in = {request_ff[23:0], b};
            end
            if (hdr_idx_ff == HDR_LAST_IDX) begin
               hdr_idx_in = 3'd0;
               phase_in   = PH_TAG;
            end else begin
               hdr_idx_in = hdr_idx_ff + 3'd1;
               if (fin) begin
                  err = ERR_HDR_SHORT;
               end
            end
         end
         PH_TAG: begin
            empty_name_in = 1'b0;
            if (b <= DELIM_MAX) begin
               role = ROLE_DELIM;
               if (b == TAG_END) begin
                  phase_in = PH_DONE;
               end else if (b == TAG_OPERATION) begin
                  group_in = GROUP_OPERATION;
               end else if (b == TAG_JOB) begin
                  group_in = GROUP_JOB;
               end else begin
                  // printer, and the fallback for unknown delimiters
                  group_in = GROUP_PRINTER;
               end
            end else begin
               role     = ROLE_TAG;
               tag_in   = b;
               phase_in = PH_NLEN_HI;
            end
         end
         PH_NLEN_HI: begin
            role      = ROLE_NAMELEN;
            len_hi_in = b;
            phase_in  = PH_NLEN_LO;
         end
         PH_NLEN_LO: begin
            role = ROLE_NAMELEN;
            if (len_word == 16'd0) begin
               empty_name_in = 1'b1;
               phase_in      = PH_VLEN_HI;
            end else begin
               remain_in = len_word;
               phase_in  = PH_NAME;
            end
         end
         PH_NAME: begin
            role      = ROLE_NAME;
            remain_in = remain_ff - 16'd1;
            if (remain_ff == 16'd1) begin
               phase_in = PH_VLEN_HI;
            end
         end
         PH_VLEN_HI: begin
            role      = ROLE_VALLEN;
            len_hi_in = b;
            phase_in  = PH_VLEN_LO;
         end
         PH_VLEN_LO: begin
            role = ROLE_VALLEN;
            if (len_word == 16'd0) begin
               done     = 1'b1;
               phase_in = PH_TAG;
            end else begin
               remain_in = len_word;
               phase_in  = PH_VALUE;
            end
         end
         PH_VALUE: begin
            role      = ROLE_VALUE;
            remain_in = remain_ff - 16'd1;
            if (remain_ff == 16'd1) begin
               done     = 1'b1;
               phase_in = PH_TAG;
            end
         end
         default: begin
            role = ROLE_IGNORED;
         end
      endcase

      // Flag a response that ends in the middle of an attribute
      if (fin && phase_in != PH_HEADER && phase_in != PH_TAG && phase_in != PH_DONE) begin
         err = ERR_TRUNC;
      end
   end

   always_comb begin
      result.out_byte     = b;
      result.byte_role    = role;
      result.group_code   = group_in;
      result.value_tag    = tag_in;
      result.repeat_name  = empty_name_in;
      result.attr_done    = done;
      result.status_word  = status_in;
      result.request_word = request_in;
      result.end_error    = err;
      result.final_out    = fin;
   end

   // Pipeline valids and payloads
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   // Parse state: advance with each item, restart after a final byte
   always_ff @(posedge clock) begin
      if (reset || (advance && fin)) begin
         phase_ff      <= PH_HEADER;
         hdr_idx_ff    <= 3'd0;
         status_ff     <= 16'd0;
         request_ff    <= 32'd0;
         group_ff      <= GROUP_OPERATION;
         tag_ff        <= 8'd0;
         remain_ff     <= 16'd0;
         len_hi_ff     <= 8'd0;
         empty_name_ff <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         hdr_idx_ff    <= hdr_idx_in;
         status_ff     <= status_in;
         request_ff    <= request_in;
         group_ff      <= group_in;
         tag_ff        <= tag_in;
         remain_ff     <= remain_in;
         len_hi_ff     <= len_hi_in;
         empty_name_ff <= empty_name_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // An end report only ever accompanies a final byte
   a_err_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.end_error != ERR_NONE |-> rsp_item.final_out)
      else $error("end_error set on a non-final item");

   // Only the closing byte of a value length or a value completes an attribute
   a_done_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.attr_done |->
         rsp_item.byte_role == ROLE_VALLEN || rsp_item.byte_role == ROLE_VALUE)
      else $error("attr_done on a byte of the wrong role");

   // A final item sends the parser back to the start of the header
   a_final_restart: assert property (@(posedge clock) disable iff (reset)
      advance && fin |=> phase_ff == PH_HEADER && hdr_idx_ff == 3'd0)
      else $error("parse state not restarted after final item");

   // Input stalls only when both stages hold items and the result is not taken
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a full pipeline");

endmodule
